// ===== rtl/psq_pkg.sv =====
// shared types, sizes and codes for the sorted priority queue
package psq_pkg;

    // number of cells in the chain
    localparam int DEPTH = 16;
    // width of the entry count, wide enough to hold DEPTH itself
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam int PRIO_W  = 8;
    localparam int TAG_W   = 16;
    localparam int BURST_W = 16;
    localparam int OCC_W   = 5;
    localparam int STAT_W  = 2;

    // input operation codes
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_REMOVE = 1'b1;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    // one queue entry
    typedef struct packed {
        logic [BURST_W-1:0] burst;
        logic [TAG_W-1:0]   tag;
        logic [PRIO_W-1:0]  prio;
    } entry_t;

    // command broadcast to every cell
    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_INSERT,
        CMD_REMOVE
    } cell_cmd_t;

    // per-cell control from the top level
    typedef struct packed {
        cell_cmd_t cmd;
        logic      occupied;
    } cell_ctrl_t;

endpackage

// ===== rtl/psq_cell.sv =====
// one queue cell: holds an entry and shifts with its neighbors
module psq_cell (
    input  logic                clk,
    input  psq_pkg::cell_ctrl_t ctrl,
    input  psq_pkg::entry_t     new_entry,
    input  psq_pkg::entry_t     left_entry,
    input  psq_pkg::entry_t     right_entry,
    input  logic                left_lower,
    output psq_pkg::entry_t     entry,
    output logic                lower
);

    psq_pkg::entry_t entry_reg;
    psq_pkg::entry_t entry_next;

    // this slot is empty or holds a strictly lower priority than the new entry
    assign lower = !ctrl.occupied || (entry_reg.prio < new_entry.prio);

    // choose what the cell holds next
    always_comb
    begin
        entry_next = entry_reg;
        case (ctrl.cmd)
            psq_pkg::CMD_INSERT:
            begin
                if (left_lower)
                begin
                    entry_next = left_entry;
                end
                else if (lower)
                begin
                    entry_next = new_entry;
                end
            end
            psq_pkg::CMD_REMOVE:
            begin
                entry_next = right_entry;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    // payload register
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ===== rtl/priority_sorted_process_queue.sv =====
// top level of the sorted priority queue: cell chain, count and result register
//
//  channel  dir  tdata                                      tuser
//  s_axis   in   prio[7:0] tag[23:8] burst[39:24]           func[0]
//  m_axis   out  prio[7:0] tag[23:8] burst[39:24] occ[44:40] status[1:0]
//
// one request per cycle unless the result stalls; every cell compares against
// the new entry and shifts in the same cycle; the result shows the cycle after.
// reset empties the queue (count to zero) and drops any pending result.
// a stalled result holds in the output register; a new request is taken
// in the cycle that result leaves.
module priority_sorted_process_queue (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // priority_req, process_tag, burst_time
    input  logic [0:0]  s_axis_tuser,   // func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // out_priority, out_tag, out_burst, occupancy
    output logic [1:0]  m_axis_tuser    // status
);

    localparam int N = psq_pkg::DEPTH;
    localparam int CW = psq_pkg::CNT_W;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [psq_pkg::STAT_W-1:0]    out_status_reg;
    logic [psq_pkg::STAT_W-1:0]    out_status_next;
    psq_pkg::entry_t               out_entry_reg;
    psq_pkg::entry_t               out_entry_next;
    logic [psq_pkg::OCC_W-1:0]     out_occ_reg;

    psq_pkg::entry_t   new_entry;
    psq_pkg::entry_t   cell_entry [N];
    logic [N-1:0]      cell_lower;
    psq_pkg::cell_cmd_t cmd;
    logic              accept;
    logic              is_full;
    logic              is_empty;

    assign new_entry = s_axis_tdata;
    assign accept = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign is_full = (count_reg == CW'(N));
    assign is_empty = (count_reg == '0);

    // decode the request into a chain command, status and new count
    always_comb
    begin
        cmd = psq_pkg::CMD_HOLD;
        count_next = count_reg;
        out_status_next = psq_pkg::ST_OK;
        out_entry_next = '0;
        if (accept)
        begin
            case (s_axis_tuser[0])
                psq_pkg::FUNC_INSERT:
                begin
                    if (is_full)
                    begin
                        out_status_next = psq_pkg::ST_FULL;
                    end
                    else
                    begin
                        cmd = psq_pkg::CMD_INSERT;
                        count_next = count_reg + CW'(1);
                    end
                end
                default:
                begin
                    if (is_empty)
                    begin
                        out_status_next = psq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        cmd = psq_pkg::CMD_REMOVE;
                        count_next = count_reg - CW'(1);
                        out_entry_next = cell_entry[0];
                    end
                end
            endcase
        end
    end

    // result valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // cell chain
    for (genvar i = 0; i < N; i++)
    begin : g_cell
        psq_pkg::cell_ctrl_t ctrl;
        psq_pkg::entry_t     left_e;
        psq_pkg::entry_t     right_e;
        logic                left_l;

        assign ctrl.cmd = cmd;
        assign ctrl.occupied = (CW'(i) < count_reg);

        if (i == 0)
        begin : g_head
            assign left_e = new_entry;
            assign left_l = 1'b0;
        end
        else
        begin : g_body
            assign left_e = cell_entry[i-1];
            assign left_l = cell_lower[i-1];
        end

        if (i == N - 1)
        begin : g_tail
            assign right_e = '0;
        end
        else
        begin : g_inner
            assign right_e = cell_entry[i+1];
        end

        psq_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .new_entry   (new_entry),
            .left_entry  (left_e),
            .right_entry (right_e),
            .left_lower  (left_l),
            .entry       (cell_entry[i]),
            .lower       (cell_lower[i])
        );
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_status_reg <= out_status_next;
            out_entry_reg <= out_entry_next;
            out_occ_reg <= psq_pkg::OCC_W'(count_next);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser = out_status_reg;
    assign m_axis_tdata = {3'b000, out_occ_reg, out_entry_reg};

    // count never goes past the number of cells
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(N))
        else $error("entry count above depth");

    // a remove on a non-empty queue returns the old head
    a_remove_head: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_axis_tuser[0] == psq_pkg::FUNC_REMOVE && !is_empty)
        |=> (m_axis_tuser == psq_pkg::ST_OK
             && m_axis_tdata[39:0] == $past(cell_entry[0])))
        else $error("remove did not return head entry");

    // an insert on a full queue leaves the count alone and flags it
    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_axis_tuser[0] == psq_pkg::FUNC_INSERT && is_full)
        |=> (m_axis_tuser == psq_pkg::ST_FULL && $stable(count_reg)))
        else $error("full insert not dropped");

    // the two front entries stay in priority order
    a_sorted_front: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= CW'(2)) |-> (cell_entry[0].prio >= cell_entry[1].prio))
        else $error("queue front out of order");

endmodule

// ===== dv/priority_sorted_process_queue_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the sorted priority queue with random flow control
module priority_sorted_process_queue_tb;

    localparam int RANDOM_REQS = 1600;

    // one result as it leaves the block
    typedef struct packed {
        logic [psq_pkg::STAT_W-1:0]  status;
        logic [psq_pkg::PRIO_W-1:0]  prio;
        logic [psq_pkg::TAG_W-1:0]   tag;
        logic [psq_pkg::BURST_W-1:0] burst;
        logic [psq_pkg::OCC_W-1:0]   occ;
    } queue_result_t;

    // shadow of the sorted queue plus the results still owed by the block
    class sorted_queue_scoreboard;
        psq_pkg::entry_t shadow_entries[$];
        queue_result_t   owed_results[$];
        int unsigned     errors;

        function new();
            errors = 0;
        endfunction

        // apply one accepted request to the shadow queue and note its result
        function void note_request(logic func, psq_pkg::entry_t req_entry);
            queue_result_t   r;
            psq_pkg::entry_t head;
            int              pos;
            r = '0;
            r.status = psq_pkg::ST_OK;
            if (func == psq_pkg::FUNC_INSERT)
            begin
                if (shadow_entries.size() >= psq_pkg::DEPTH)
                begin
                    r.status = psq_pkg::ST_FULL;
                end
                else
                begin
                    // new entry goes behind every entry of equal or higher priority
                    pos = 0;
                    while (pos < shadow_entries.size()
                           && shadow_entries[pos].prio >= req_entry.prio)
                        pos++;
                    shadow_entries.insert(pos, req_entry);
                end
            end
            else
            begin
                if (shadow_entries.size() == 0)
                begin
                    r.status = psq_pkg::ST_EMPTY;
                end
                else
                begin
                    head    = shadow_entries.pop_front();
                    r.prio  = head.prio;
                    r.tag   = head.tag;
                    r.burst = head.burst;
                end
            end
            r.occ = psq_pkg::OCC_W'(shadow_entries.size());
            owed_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        // compare one accepted result with the oldest owed one
        function void check_result(queue_result_t got);
            queue_result_t want;
            if (owed_results.size() == 0)
            begin
                $error("result with no request owed: status %0d", got.status);
                errors++;
                return;
            end
            want = owed_results.pop_front();
            compare_field("status", 16'(want.status), 16'(got.status));
            compare_field("out_priority", 16'(want.prio), 16'(got.prio));
            compare_field("out_tag", want.tag, got.tag);
            compare_field("out_burst", want.burst, got.burst);
            compare_field("occupancy", 16'(want.occ), 16'(got.occ));
        endfunction

        function int unsigned owed();
            return owed_results.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;   // priority_req, process_tag, burst_time
    logic [0:0]  s_axis_tuser;   // func
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;   // out_priority, out_tag, out_burst, occupancy
    logic [1:0]  m_axis_tuser;   // status

    sorted_queue_scoreboard sb;
    queue_result_t          seen_result;
    int unsigned            burst_left;
    bit                     gaps_on;
    int unsigned            req_count;

    priority_sorted_process_queue dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // run limit
    initial
    begin
        #2ms;
        $display("priority_sorted_process_queue_tb: FAIL");
        $finish;
    end

    // drive one request and hold it until accepted, with gaps between bursts when gaps_on is set
    task automatic send_req(logic func, logic [psq_pkg::PRIO_W-1:0] prio,
                            logic [psq_pkg::TAG_W-1:0] tag,
                            logic [psq_pkg::BURST_W-1:0] burst);
        int unsigned     gap;
        psq_pkg::entry_t req_entry;
        if (gaps_on && burst_left == 0)
        begin
            gap        = $urandom_range(0, 10);
            burst_left = $urandom_range(1, 24);
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= {burst, tag, prio};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        req_entry.prio  = prio;
        req_entry.tag   = tag;
        req_entry.burst = burst;
        sb.note_request(func, req_entry);
        if (burst_left != 0)
            burst_left--;
    endtask

    // stop sending until every owed result has come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (sb.owed() != 0);
    endtask

    // one random request; prio_mode picks full range, a narrow band or the extremes
    task automatic send_random_req(int unsigned ins_pct, int unsigned prio_mode,
                                   logic [psq_pkg::PRIO_W-1:0] prio_base);
        logic                       func;
        logic [psq_pkg::PRIO_W-1:0] prio;
        func = ($urandom_range(0, 99) < ins_pct) ? psq_pkg::FUNC_INSERT
                                                 : psq_pkg::FUNC_REMOVE;
        case (prio_mode)
            0: prio = psq_pkg::PRIO_W'($urandom);
            1: prio = prio_base + psq_pkg::PRIO_W'($urandom_range(0, 2));
            default: prio = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        endcase
        send_req(func, prio, psq_pkg::TAG_W'($urandom), psq_pkg::BURST_W'($urandom));
    endtask

    // stimulus
    initial
    begin
        int unsigned                seg_len;
        int unsigned                ins_pct;
        int unsigned                prio_mode;
        logic [psq_pkg::PRIO_W-1:0] prio_base;
        sb            = new();
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        burst_left    = 0;
        gaps_on       = 1'b0;
        req_count     = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // remove on an empty queue
        send_req(psq_pkg::FUNC_REMOVE, 8'h00, 16'h0000, 16'h0000);
        // field extremes and ties at both ends of the order
        send_req(psq_pkg::FUNC_INSERT, 8'h00, 16'h0000, 16'h0000);
        send_req(psq_pkg::FUNC_INSERT, 8'hFF, 16'hFFFF, 16'hFFFF);
        send_req(psq_pkg::FUNC_INSERT, 8'hFF, 16'h0001, 16'h0002);
        send_req(psq_pkg::FUNC_INSERT, 8'h00, 16'h0003, 16'h0004);
        // fill the queue to the top
        for (int i = 0; i < psq_pkg::DEPTH - 4; i++)
            send_req(psq_pkg::FUNC_INSERT, psq_pkg::PRIO_W'(i * 37 + 5),
                     psq_pkg::TAG_W'($urandom), psq_pkg::BURST_W'($urandom));
        // insert on a full queue is dropped
        send_req(psq_pkg::FUNC_INSERT, 8'h80, 16'hAAAA, 16'h5555);
        // removes carry payload that must be ignored
        repeat (3) send_req(psq_pkg::FUNC_REMOVE, 8'hFF, 16'hFFFF, 16'hFFFF);
        drain();

        // random segments with their own mix of inserts and removes
        while (req_count < RANDOM_REQS)
        begin
            seg_len   = $urandom_range(20, 120);
            case ($urandom_range(0, 3))
                0: ins_pct = 30;
                1: ins_pct = 50;
                2: ins_pct = 70;
                default: ins_pct = 90;
            endcase
            prio_mode = $urandom_range(0, 2);
            prio_base = psq_pkg::PRIO_W'($urandom);
            gaps_on   = ($urandom_range(0, 3) != 0);
            repeat (seg_len)
            begin
                send_random_req(ins_pct, prio_mode, prio_base);
                req_count++;
            end
            if ($urandom_range(0, 3) == 0)
                drain();
        end
        drain();
        repeat (20) @(posedge clk);

        if (sb.errors == 0)
            $display("priority_sorted_process_queue_tb: PASS");
        else
            $display("priority_sorted_process_queue_tb: FAIL");
        $finish;
    end

    // receiver stalls: always ready, coin flip, or periodic patterns
    initial
    begin
        int unsigned mode;
        int unsigned len;
        int unsigned period;
        m_axis_tready = 1'b0;
        forever
        begin
            mode   = $urandom_range(0, 3);
            len    = $urandom_range(16, 160);
            period = $urandom_range(2, 40);
            for (int unsigned k = 0; k < len; k++)
            begin
                @(posedge clk);
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= 1'($urandom_range(0, 1));
                    2: m_axis_tready <= ((k % period) == 0);
                    default: m_axis_tready <= ((k % period) >= period / 2);
                endcase
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen_result.status = m_axis_tuser;
            seen_result.prio   = m_axis_tdata[7:0];
            seen_result.tag    = m_axis_tdata[23:8];
            seen_result.burst  = m_axis_tdata[39:24];
            seen_result.occ    = m_axis_tdata[44:40];
            sb.check_result(seen_result);
        end
    end

endmodule

// ===== sim.f =====
rtl/psq_pkg.sv
rtl/psq_cell.sv
rtl/priority_sorted_process_queue.sv
dv/priority_sorted_process_queue_tb.sv
